// ----- hdl/modular_exponentiation_core_macros.svh -----
// Assertion helpers shared by the core.
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MEC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/modexp_pkg.sv -----
`timescale 1ns / 1ps

package modexp_pkg;

   localparam int WORD_BITS = 64;
   localparam int PORT_BITS = 64;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL,
      ST_SQR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic     start;
      word_type multiplicand;
      word_type multiplier;
      word_type modulus;
   } mm_req_type;

   typedef struct packed {
      logic     done;
      word_type product;
   } mm_rsp_type;

   // (x + y) mod m for x, y < m
   function automatic word_type add_mod(input word_type x, input word_type y,
                                        input word_type m);
      logic [WORD_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WORD_BITS-1:0];
   endfunction

endpackage

// ----- hdl/modexp_cell.sv -----
`timescale 1ns / 1ps

// One multiplier bit; loads in parallel, then passes its bit up the row.
module modexp_cell (
   input  logic clock,
   input  logic load,
   input  logic shift,
   input  logic load_bit,
   input  logic prev_bit,
   output logic bit_out
);

   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = prev_bit;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule

// ----- hdl/modexp_mulmod.sv -----
`timescale 1ns / 1ps

// Interleaved shift-add modular multiply, multiplier MSB first, one bit per cycle.
module modexp_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  modexp_pkg::mm_req_type req,
   output modexp_pkg::mm_rsp_type rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [modexp_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   modexp_pkg::word_type         r_ff, r_in;
   modexp_pkg::word_type         a_ff, a_in;
   modexp_pkg::word_type         m_ff, m_in;
   logic [modexp_pkg::WORD_BITS-1:0] chain_bits;
   logic [modexp_pkg::WORD_BITS-1:0] chain_prev;
   modexp_pkg::word_type         dbl;

   assign chain_prev = {chain_bits[modexp_pkg::WORD_BITS-2:0], 1'b0};

   for (genvar i = 0; i < modexp_pkg::WORD_BITS; i++) begin : g_cell
      modexp_cell u_cell (
         .clock    (clock),
         .load     (req.start),
         .shift    (busy_ff),
         .load_bit (req.multiplier[i]),
         .prev_bit (chain_prev[i]),
         .bit_out  (chain_bits[i])
      );
   end

   always_comb begin
      dbl     = modexp_pkg::add_mod(r_ff, r_ff, m_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = modexp_pkg::CNT_BITS'(modexp_pkg::WORD_BITS - 1);
         r_in    = '0;
         a_in    = req.multiplicand;
         m_in    = req.modulus;
      end else if (busy_ff) begin
         r_in = chain_bits[modexp_pkg::WORD_BITS-1]
              ? modexp_pkg::add_mod(dbl, a_ff, m_ff) : dbl;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = r_ff;

endmodule

// ----- hdl/modular_exponentiation_core.sv -----
// Modular exponentiation core: returns base^exponent mod modulus, one result
// beat per request beat, for 64-bit unsigned operands. Base is reduced first,
// then the exponent is scanned from its LSB (right-to-left square-and-multiply).
// Every modular product is exact: a row of 64 bit cells feeds the multiplier
// MSB first into a shift-add reduce loop, one bit per cycle. Each exponent
// bit up to the highest set bit costs a square, and each set bit a multiply
// as well. Zero exponent gives 1 (even for modulus one); zero modulus gives
// power_mod 0 with zero_modulus set.
// One request is in flight at a time; req_stall is high while it computes.
// A finished result waits in the output register, so the next request may be
// taken while the previous beat is still stalled.
`timescale 1ns / 1ps

`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [modexp_pkg::PORT_BITS-1:0] req_base,
   input  logic [modexp_pkg::PORT_BITS-1:0] req_exponent,
   input  logic [modexp_pkg::PORT_BITS-1:0] req_modulus,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [modexp_pkg::PORT_BITS-1:0] rsp_power_mod,
   output logic                             rsp_zero_modulus
);

   modexp_pkg::state_type  state_ff, state_in;
   modexp_pkg::word_type   b_ff, b_in;
   modexp_pkg::word_type   e_ff, e_in;
   modexp_pkg::word_type   m_ff, m_in;
   modexp_pkg::word_type   acc_ff, acc_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   modexp_pkg::word_type   rsp_pm_ff, rsp_pm_in;
   logic                   rsp_zm_ff, rsp_zm_in;
   modexp_pkg::mm_req_type mm_req;
   modexp_pkg::mm_rsp_type mm_rsp;
   logic                   req_take;
   logic                   rsp_free;
   modexp_pkg::word_type   in_b, in_e, in_m;

   // only the low WORD_BITS of each operand take part
   assign in_b = req_base[modexp_pkg::WORD_BITS-1:0];
   assign in_e = req_exponent[modexp_pkg::WORD_BITS-1:0];
   assign in_m = req_modulus[modexp_pkg::WORD_BITS-1:0];

   assign req_stall = (state_ff != modexp_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   modexp_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .req   (mm_req),
      .rsp   (mm_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (in_m == '0) ? modexp_pkg::ST_FINISH : modexp_pkg::ST_REDUCE;
            end
         end
         modexp_pkg::ST_REDUCE: begin
            if (mm_rsp.done) begin
               state_in = modexp_pkg::ST_CHECK;
            end
         end
         modexp_pkg::ST_CHECK: begin
            if (e_ff == '0) begin
               state_in = modexp_pkg::ST_FINISH;
            end else if (e_ff[0]) begin
               state_in = modexp_pkg::ST_MUL;
            end else begin
               state_in = modexp_pkg::ST_SQR;
            end
         end
         modexp_pkg::ST_MUL: begin
            if (mm_rsp.done) begin
               state_in = modexp_pkg::ST_SQR;
            end
         end
         modexp_pkg::ST_SQR: begin
            if (mm_rsp.done) begin
               state_in = modexp_pkg::ST_CHECK;
            end
         end
         modexp_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = modexp_pkg::ST_IDLE;
            end
         end
         default: state_in = modexp_pkg::ST_IDLE;
      endcase
   end

   // multiplier launches
   always_comb begin
      mm_req.start        = 1'b0;
      mm_req.multiplicand = b_ff;
      mm_req.multiplier   = b_ff;
      mm_req.modulus      = m_ff;
      unique case (state_ff)
         modexp_pkg::ST_IDLE: begin
            // base mod m == 1 * base mod m
            mm_req.start        = req_take && (in_m != '0);
            mm_req.multiplicand = modexp_pkg::word_type'(1);
            mm_req.multiplier   = in_b;
            mm_req.modulus      = in_m;
         end
         modexp_pkg::ST_CHECK: begin
            mm_req.start      = (e_ff != '0);
            mm_req.multiplier = e_ff[0] ? acc_ff : b_ff;
         end
         modexp_pkg::ST_MUL: begin
            // square follows the accumulate step
            mm_req.start = mm_rsp.done;
         end
         default: begin
            mm_req.start = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      b_in         = b_ff;
      e_in         = e_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pm_in    = rsp_pm_ff;
      rsp_zm_in    = rsp_zm_ff;
      if (req_take) begin
         e_in   = in_e;
         m_in   = in_m;
         acc_in = modexp_pkg::word_type'(1);
         err_in = (in_m == '0);
      end
      if (mm_rsp.done) begin
         if (state_ff == modexp_pkg::ST_MUL) begin
            acc_in = mm_rsp.product;
         end else begin
            b_in = mm_rsp.product;
         end
         if (state_ff == modexp_pkg::ST_SQR) begin
            e_in = e_ff >> 1;
         end
      end
      if (state_ff == modexp_pkg::ST_FINISH && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_pm_in    = err_ff ? '0 : acc_ff;
         rsp_zm_in    = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff      <= b_in;
      e_ff      <= e_in;
      m_ff      <= m_in;
      acc_ff    <= acc_in;
      err_ff    <= err_in;
      rsp_pm_ff <= rsp_pm_in;
      rsp_zm_ff <= rsp_zm_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_mod    = modexp_pkg::PORT_BITS'(rsp_pm_ff);
   assign rsp_zero_modulus = rsp_zm_ff;

   `MEC_ASSERT_NOW(a_done_in_compute, mm_rsp.done, (state_ff == modexp_pkg::ST_REDUCE) || (state_ff == modexp_pkg::ST_MUL) || (state_ff == modexp_pkg::ST_SQR), "multiply finished outside a compute state")
   `MEC_ASSERT_NOW(a_err_zero, rsp_valid_ff && rsp_zm_ff, rsp_pm_ff == '0, "zero modulus result not zero")
   `MEC_ASSERT_NEXT(a_check_exit, (state_ff == modexp_pkg::ST_CHECK) && (e_ff == '0), state_ff == modexp_pkg::ST_FINISH, "exhausted exponent did not finish")

endmodule
